FILE: src/bmap_pkg.sv
// ----------------------------------------------------------------------------
// bmap_pkg
// shared types and constants for the bitmap set, clear and find block
// ----------------------------------------------------------------------------
package bmap_pkg;

    localparam int ACT_W = 3;
    localparam int IDX_W = 12;
    localparam int POS_W = 13;

    localparam int NUM_BITS_DEF  = 4096;
    localparam int WORD_BITS_DEF = 64;

    localparam logic [ACT_W-1:0] ACT_SET   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TEST  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIRST = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NEXT  = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] bit_index;
    } bmap_in_t;

    typedef struct packed {
        logic             bit_value;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] current_length;
        logic             bad_request;
    } bmap_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_SCAN
    } state_t;

endpackage

FILE: src/bmap_ram.sv
// ----------------------------------------------------------------------------
// bmap_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module bmap_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/bitmap_set_clear_find_next.sv
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_next
// bitmap with set, clear, test, find first and find next set bit
// ----------------------------------------------------------------------------
// A command is taken on a rising edge with start high and busy low; request
// carries the action and the bit index. Every command yields one result beat
// on result, marked by done for exactly one cycle. The receiver cannot stall.
// Set, clear and test do a read-modify-write of one word in the ram, read in
// ST_FETCH and written in ST_UPDATE, which also registers the result. Finds
// with an empty range, a find-next at or past the length, and unknown actions
// answer in the cycle after the command is taken. Other finds read one word
// per cycle from the start word until a word holds a set bit at or past the
// start, or up to the word that holds bit length-1. busy is high while a command
// is in flight and falls in the cycle its result is shown, so a new command
// may be given then. One ram read port sets the scan rate.
// Reset empties the bitmap and zeroes the length at once through one valid
// flop per ram word; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_set_clear_find_next
    import bmap_pkg::*;
#(
    parameter int NUM_BITS  = NUM_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  bmap_in_t  request,
    output logic      done,
    output bmap_out_t result
);

    localparam int WIDX      = $clog2(WORD_BITS);
    localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WN_W      = POS_W + 1;

    state_t                 state_reg, state_next;
    logic [ACT_W-1:0]       act_reg, act_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [POS_W-1:0]       len_reg, len_next;
    logic [(1<<AW)-1:0]     valid_reg, valid_next;
    logic [WN_W-1:0]        cur_reg, cur_next;
    logic [WN_W-1:0]        last_reg, last_next;
    logic [WIDX-1:0]        low_reg, low_next;
    logic                   first_reg, first_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic                   chk_first_reg, chk_first_next;
    logic [WN_W-1:0]        chk_word_reg, chk_word_next;
    logic                   rd_valid_reg;
    logic                   done_reg, done_next;
    bmap_out_t              result_reg, result_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    logic [POS_W-1:0]       from_pos;
    logic                   req_below;
    logic                   ram_op;
    logic                   scan_go;
    logic                   issue;
    logic [WORD_BITS-1:0]   rd_word;
    logic [WORD_BITS-1:0]   scan_mask;
    logic [WORD_BITS-1:0]   scan_word;
    logic                   hit;
    logic                   scan_end;
    logic [WORD_BITS-1:0]   bit_sel;
    logic                   idx_below;
    logic                   idx_in_store;
    logic [AW-1:0]          idx_addr;

    function automatic logic [WIDX-1:0] low_bit(input logic [WORD_BITS-1:0] w);
        logic [WIDX-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                p = WIDX'(i);
            end
        end
        return p;
    endfunction

    bmap_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign from_pos  = (request.action == ACT_FIRST) ? '0
                                                     : POS_W'(request.bit_index) + POS_W'(1);
    assign req_below = POS_W'(request.bit_index) < len_reg;
    assign ram_op    = request.action inside {ACT_SET, ACT_CLEAR, ACT_TEST};
    assign scan_go   = ((request.action == ACT_FIRST) ||
                        ((request.action == ACT_NEXT) && req_below)) &&
                       (from_pos < len_reg);

    assign issue     = cur_reg <= last_reg;
    assign rd_word   = rd_valid_reg ? ram_rdata : '0;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            scan_mask[i] = !chk_first_reg || (WIDX'(i) >= low_reg);
        end
    end

    assign scan_word = rd_word & scan_mask;
    assign hit       = chk_vld_reg && (|scan_word);
    assign scan_end  = chk_vld_reg && (hit || (chk_word_reg == last_reg));

    assign bit_sel      = WORD_BITS'(1) << idx_reg[WIDX-1:0];
    assign idx_below    = POS_W'(idx_reg) < len_reg;
    assign idx_in_store = {{(32-IDX_W){1'b0}}, idx_reg} < 32'(NUM_BITS);
    assign idx_addr     = AW'(idx_reg >> WIDX);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (ram_op)
                    begin
                        state_next = ST_FETCH;
                    end
                    else if (scan_go)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FETCH:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        act_next       = act_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        valid_next     = valid_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        low_next       = low_reg;
        first_next     = first_reg;
        chk_vld_next   = 1'b0;
        chk_first_next = chk_first_reg;
        chk_word_next  = chk_word_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_addr;
        ram_wdata      = rd_word;
        ram_re         = 1'b0;
        ram_raddr      = idx_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next   = request.action;
                    idx_next   = request.bit_index;
                    cur_next   = WN_W'(from_pos >> WIDX);
                    last_next  = WN_W'((len_reg - POS_W'(1)) >> WIDX);
                    low_next   = from_pos[WIDX-1:0];
                    first_next = 1'b1;
                    if (!ram_op && !scan_go)
                    begin
                        done_next                  = 1'b1;
                        result_next.bit_value      = 1'b0;
                        result_next.current_length = len_reg;
                        result_next.position       = '0;
                        result_next.bad_request    = 1'b0;
                        if ((request.action == ACT_FIRST) || (request.action == ACT_NEXT))
                        begin
                            result_next.position = len_reg;
                        end
                        if ((request.action == ACT_NEXT) && !req_below)
                        begin
                            result_next.bad_request = 1'b1;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                ram_re = 1'b1;
            end
            ST_UPDATE:
            begin
                done_next               = 1'b1;
                result_next.bit_value   = 1'b0;
                result_next.position    = '0;
                result_next.bad_request = 1'b0;
                case (act_reg)
                    ACT_SET:
                    begin
                        if (idx_in_store)
                        begin
                            ram_we               = 1'b1;
                            ram_wdata            = rd_word | bit_sel;
                            valid_next[idx_addr] = 1'b1;
                            if (!idx_below)
                            begin
                                len_next = POS_W'(idx_reg) + POS_W'(1);
                            end
                        end
                    end
                    ACT_CLEAR:
                    begin
                        if (idx_below)
                        begin
                            ram_we               = 1'b1;
                            ram_wdata            = rd_word & ~bit_sel;
                            valid_next[idx_addr] = 1'b1;
                        end
                    end
                    ACT_TEST:
                    begin
                        result_next.bit_value = idx_below && rd_word[idx_reg[WIDX-1:0]];
                    end
                    default:
                    begin
                        result_next.bit_value = 1'b0;
                    end
                endcase
                result_next.current_length = len_next;
            end
            ST_SCAN:
            begin
                ram_re         = issue && !scan_end;
                ram_raddr      = cur_reg[AW-1:0];
                chk_vld_next   = issue && !scan_end;
                chk_word_next  = cur_reg;
                chk_first_next = first_reg;
                if (issue)
                begin
                    cur_next   = cur_reg + WN_W'(1);
                    first_next = 1'b0;
                end
                if (scan_end)
                begin
                    done_next                  = 1'b1;
                    result_next.bit_value      = 1'b0;
                    result_next.current_length = len_reg;
                    result_next.bad_request    = 1'b0;
                    result_next.position       = hit
                        ? (POS_W'(chk_word_reg << WIDX) | POS_W'(low_bit(scan_word)))
                        : len_reg;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            valid_reg   <= '0;
            chk_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            valid_reg   <= valid_next;
            chk_vld_reg <= chk_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        idx_reg       <= idx_next;
        cur_reg       <= cur_next;
        last_reg      <= last_next;
        low_reg       <= low_next;
        first_reg     <= first_next;
        chk_first_reg <= chk_first_next;
        chk_word_reg  <= chk_word_next;
        result_reg    <= result_next;
        if (ram_re)
        begin
            rd_valid_reg <= valid_reg[ram_raddr];
        end
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    // a scan only runs with a nonzero length
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (len_reg != '0))
        else $error("scan with zero length");

    // the length mark never shrinks
    a_len_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg >= $past(len_reg))
        else $error("length mark decreased");

    // a reported position never lies past the length
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.position <= result.current_length))
        else $error("position beyond length");

    // a rejected find-next reports the length as its position
    a_bad_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.bad_request) |-> (result.position == result.current_length))
        else $error("bad request without length position");

endmodule

FILE: verif/bitmap_set_clear_find_next_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_next_tb
// self-checking bench for the bitmap set, clear, test and find block
// ----------------------------------------------------------------------------
// Commands are queued up front and presented by a clocked driver with
// start/busy handshaking. A shadow bitmap and length mark, updated as each
// command is taken, give the expected answer. A clocked monitor checks each
// done beat against the oldest expected answer, field by field. The length
// grows slowly over the run, so that empty maps, bad find-next requests,
// long scans and the top bit are all reached. Sender idling varies by phase.
// ----------------------------------------------------------------------------
module bitmap_set_clear_find_next_tb;
    import bmap_pkg::*;

    localparam int MAP_BITS     = NUM_BITS_DEF;
    localparam int RAND_ITEMS   = 1880;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_BEATS  = 150;

    localparam logic [ACT_W-1:0] ACT_MAX = '1;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    bmap_in_t  request = '0;
    logic      done;
    bmap_out_t result;

    bitmap_set_clear_find_next dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    bmap_in_t  cmd_fifo[$];
    bmap_out_t predicted_answers[$];
    bmap_out_t oldest_answer;

    logic [MAP_BITS-1:0] shadow_map = '0;
    int                  shadow_len = 0;

    int gen_len = 0;
    int gen_set_list[$];

    int mismatch_count = 0;
    int taken_count = 0;
    int cycle_count = 0;
    int idle_pct = 0;
    int idle_table[4] = '{0, 60, 0, 9};

    function automatic int first_set_from(int from);
        for (int i = from; i < shadow_len; i++)
        begin
            if (shadow_map[i])
                return i;
        end
        return shadow_len;
    endfunction

    function automatic bmap_out_t predict_answer(bmap_in_t cmd);
        bmap_out_t ans;
        int        idx;
        ans = '0;
        idx = int'(cmd.bit_index);
        case (cmd.action)
            ACT_SET:
            begin
                shadow_map[idx] = 1'b1;
                if (idx >= shadow_len)
                    shadow_len = idx + 1;
            end
            ACT_CLEAR:
            begin
                if (idx < shadow_len)
                    shadow_map[idx] = 1'b0;
            end
            ACT_TEST:
            begin
                ans.bit_value = (idx < shadow_len) && shadow_map[idx];
            end
            ACT_FIRST:
            begin
                ans.position = POS_W'(first_set_from(0));
            end
            ACT_NEXT:
            begin
                if (idx < shadow_len)
                    ans.position = POS_W'(first_set_from(idx + 1));
                else
                begin
                    ans.position    = POS_W'(shadow_len);
                    ans.bad_request = 1'b1;
                end
            end
            default: ;
        endcase
        ans.current_length = POS_W'(shadow_len);
        return ans;
    endfunction

    function automatic void check_field(string fname, logic [POS_W-1:0] want,
                                        logic [POS_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic add_cmd(logic [ACT_W-1:0] act, int idx);
        bmap_in_t cmd;
        cmd.action    = act;
        cmd.bit_index = idx[IDX_W-1:0];
        cmd_fifo.push_back(cmd);
        if (act == ACT_SET)
        begin
            gen_set_list.push_back(idx);
            if (idx + 1 > gen_len)
                gen_len = idx + 1;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                predicted_answers.push_back(predict_answer(request));
                void'(cmd_fifo.pop_front());
                taken_count++;
                idle_pct = idle_table[(taken_count / PHASE_BEATS) % 4];
            end
            if (!start || !busy)
            begin
                if (cmd_fifo.size() > 0 && $urandom_range(99, 0) >= idle_pct)
                begin
                    start   <= 1'b1;
                    request <= cmd_fifo[0];
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (predicted_answers.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, got %p",
                         $time, result);
                mismatch_count++;
            end
            else
            begin
                oldest_answer = predicted_answers.pop_front();
                check_field("bit_value", POS_W'(oldest_answer.bit_value),
                            POS_W'(result.bit_value));
                check_field("position", oldest_answer.position, result.position);
                check_field("current_length", oldest_answer.current_length,
                            result.current_length);
                check_field("bad_request", POS_W'(oldest_answer.bad_request),
                            POS_W'(result.bad_request));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bitmap_set_clear_find_next_tb: errors");
            $finish;
        end
    end

    initial
    begin
        int ceiling;
        int roll;
        int idx;
        bit clear_heavy;

        // empty map
        add_cmd(ACT_FIRST, 0);
        add_cmd(ACT_NEXT, 0);
        add_cmd(ACT_NEXT, MAP_BITS - 1);
        add_cmd(ACT_TEST, 0);
        add_cmd(ACT_TEST, MAP_BITS - 1);
        add_cmd(ACT_CLEAR, 5);
        add_cmd(ACT_NEXT + 3'd1, MAP_BITS - 1);
        add_cmd(ACT_MAX - 3'd1, 0);
        add_cmd(ACT_MAX, 2730);
        // single bit, then word boundaries
        add_cmd(ACT_SET, 0);
        add_cmd(ACT_TEST, 0);
        add_cmd(ACT_FIRST, 0);
        add_cmd(ACT_NEXT, 0);
        add_cmd(ACT_NEXT, 1);
        add_cmd(ACT_SET, 63);
        add_cmd(ACT_SET, 64);
        add_cmd(ACT_NEXT, 0);
        add_cmd(ACT_NEXT, 63);
        add_cmd(ACT_CLEAR, 63);
        add_cmd(ACT_NEXT, 0);
        add_cmd(ACT_CLEAR, 0);
        add_cmd(ACT_FIRST, 0);
        add_cmd(ACT_TEST, 63);
        add_cmd(ACT_CLEAR, 64);
        add_cmd(ACT_FIRST, 0);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            ceiling     = 80 + (n * 3900) / RAND_ITEMS;
            clear_heavy = ((n / 200) % 2) == 1;
            roll        = $urandom_range(99, 0);
            if (roll < (clear_heavy ? 12 : 30))
                add_cmd(ACT_SET, $urandom_range(ceiling, 0));
            else if (roll < 45)
            begin
                if ($urandom_range(9, 0) < 7 && gen_set_list.size() > 0)
                    idx = gen_set_list[$urandom_range(gen_set_list.size() - 1, 0)];
                else
                    idx = $urandom_range(MAP_BITS - 1, 0);
                add_cmd(ACT_CLEAR, idx);
            end
            else if (roll < 65)
            begin
                if ($urandom_range(1, 0) == 1 && gen_set_list.size() > 0)
                    idx = gen_set_list[$urandom_range(gen_set_list.size() - 1, 0)];
                else
                    idx = $urandom_range(MAP_BITS - 1, 0);
                add_cmd(ACT_TEST, idx);
            end
            else if (roll < 75)
                add_cmd(ACT_FIRST, $urandom_range(MAP_BITS - 1, 0));
            else if (roll < 95)
            begin
                roll = $urandom_range(99, 0);
                if (roll < 15)
                    idx = (gen_len > 0) ? gen_len - 1 + $urandom_range(1, 0) : 0;
                else if (roll < 30 || gen_len == 0)
                    idx = $urandom_range(MAP_BITS - 1, 0);
                else
                    idx = $urandom_range(gen_len - 1, 0);
                if (idx > MAP_BITS - 1)
                    idx = MAP_BITS - 1;
                add_cmd(ACT_NEXT, idx);
            end
            else
                add_cmd(ACT_W'($urandom_range(ACT_MAX, ACT_NEXT + 1)),
                        $urandom_range(MAP_BITS - 1, 0));
        end

        // top bit last, since the length never shrinks
        add_cmd(ACT_SET, MAP_BITS - 1);
        add_cmd(ACT_TEST, MAP_BITS - 1);
        add_cmd(ACT_NEXT, MAP_BITS - 2);
        add_cmd(ACT_NEXT, MAP_BITS - 1);
        add_cmd(ACT_FIRST, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_fifo.size() != 0 || start)
            @(posedge clk);
        while (predicted_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("bitmap_set_clear_find_next_tb: clean");
        else
            $display("bitmap_set_clear_find_next_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
src/bmap_pkg.sv
src/bmap_ram.sv
src/bitmap_set_clear_find_next.sv
verif/bitmap_set_clear_find_next_tb.sv
